// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file lws_checker.sv.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lws_pkg.sv -----
// Shared types and constants for the lidar window steering core.
// No dependencies; imported by every module of the block.
package lws_pkg;

  localparam int AHEAD_LEN_DEF   = 23;
  localparam int SIDE_LEN_DEF    = 136;
  localparam int PATH_LEN_DEF    = 540;
  localparam int INDEX_BITS_DEF  = 12;
  localparam int RANGE_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int RANGE_W     = 16;
  localparam int AHEAD_SUM_W = 24;
  localparam int SIDE_SUM_W  = 26;
  localparam int CFG_IDX_W   = 12;
  localparam int THR_W       = 16;
  localparam int TURN_W      = 12;
  localparam int GAIN_W      = 16;
  localparam int STEER_W     = 13;
  localparam int REG_ADDR_W  = 3;
  localparam int REG_DATA_W  = 16;

  localparam logic [REG_ADDR_W-1:0] REG_AHEAD_THRESHOLD = 3'd0;
  localparam logic [REG_ADDR_W-1:0] REG_TURN            = 3'd1;
  localparam logic [REG_ADDR_W-1:0] REG_GAIN            = 3'd2;
  localparam logic [REG_ADDR_W-1:0] REG_AHEAD_FIRST     = 3'd3;
  localparam logic [REG_ADDR_W-1:0] REG_RIGHT_FIRST     = 3'd4;
  localparam logic [REG_ADDR_W-1:0] REG_LEFT_FIRST      = 3'd5;
  localparam logic [REG_ADDR_W-1:0] REG_PATH_FIRST      = 3'd6;
  localparam logic [REG_ADDR_W-1:0] REG_PATH_SPLIT      = 3'd7;

  localparam logic [THR_W-1:0]     THRESHOLD_RST   = 16'd1700;
  localparam logic [TURN_W-1:0]    TURN_RST        = 12'd600;
  localparam logic [GAIN_W-1:0]    GAIN_RST        = 16'd3932;
  localparam logic [CFG_IDX_W-1:0] AHEAD_FIRST_RST = 12'd528;
  localparam logic [CFG_IDX_W-1:0] RIGHT_FIRST_RST = 12'd202;
  localparam logic [CFG_IDX_W-1:0] LEFT_FIRST_RST  = 12'd741;
  localparam logic [CFG_IDX_W-1:0] PATH_FIRST_RST  = 12'd270;
  localparam logic [CFG_IDX_W-1:0] PATH_SPLIT_RST  = 12'd539;

  // Window placement, used by the front end.
  typedef struct packed {
    logic [CFG_IDX_W-1:0] ahead_first;
    logic [CFG_IDX_W-1:0] right_first;
    logic [CFG_IDX_W-1:0] left_first;
    logic [CFG_IDX_W-1:0] path_first;
    logic [CFG_IDX_W-1:0] path_split;
  } window_cfg_t;

  // Steering law settings, used by the back end.
  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [TURN_W-1:0] turn;
    logic [GAIN_W-1:0] gain;
  } steer_cfg_t;

  // One finished scan as handed from front to back.
  typedef struct packed {
    logic [AHEAD_SUM_W-1:0] ahead_sum;
    logic [SIDE_SUM_W-1:0]  right_sum;
    logic [SIDE_SUM_W-1:0]  left_sum;
    logic                   path_low;
  } scan_t;

  // Decisions carried along the back-end pipeline.
  typedef struct packed {
    logic obstacle;
    logic neg;
    logic path_low;
  } steer_flags_t;

endpackage

// ----- hdl/lidar_window_steering_core.sv -----
// Lidar window steering core. Takes one range sample per clock, with no gaps needed
// between scans; in_ready falls only while QUEUE_DEPTH finished scans wait for the
// steering pipeline. Each finished scan is written into the queue and then passes the
// six-stage divide-by-reciprocal pipeline behind it, which stalls while a held result
// waits for out_ready; else one result can leave every cycle. Registers: 0 threshold,
// 1 turn, 2 gain, 3..6 first index of ahead, right, left and path windows, 7 path split.
// Uses lws_pkg, lws_front, lws_queue and lws_back.
module lidar_window_steering_core import lws_pkg::*; #(
  parameter int AHEAD_LEN   = AHEAD_LEN_DEF,
  parameter int SIDE_LEN    = SIDE_LEN_DEF,
  parameter int PATH_LEN    = PATH_LEN_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int RANGE_BITS  = RANGE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [RANGE_W-1:0]        range_mm,
  input  logic                      last_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [STEER_W-1:0] steering_mrad,
  output logic                      obstacle_ahead,
  input  logic                      wr_en,
  input  logic [REG_ADDR_W-1:0]     wr_index,
  input  logic [REG_DATA_W-1:0]     wr_data
);

  window_cfg_t wcfg;
  steer_cfg_t  scfg;
  scan_t       push_data, pop_data;
  logic        q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      scfg.threshold   <= THRESHOLD_RST;
      scfg.turn        <= TURN_RST;
      scfg.gain        <= GAIN_RST;
      wcfg.ahead_first <= AHEAD_FIRST_RST;
      wcfg.right_first <= RIGHT_FIRST_RST;
      wcfg.left_first  <= LEFT_FIRST_RST;
      wcfg.path_first  <= PATH_FIRST_RST;
      wcfg.path_split  <= PATH_SPLIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_AHEAD_THRESHOLD: scfg.threshold   <= wr_data[THR_W-1:0];
        REG_TURN:            scfg.turn        <= wr_data[TURN_W-1:0];
        REG_GAIN:            scfg.gain        <= wr_data[GAIN_W-1:0];
        REG_AHEAD_FIRST:     wcfg.ahead_first <= wr_data[CFG_IDX_W-1:0];
        REG_RIGHT_FIRST:     wcfg.right_first <= wr_data[CFG_IDX_W-1:0];
        REG_LEFT_FIRST:      wcfg.left_first  <= wr_data[CFG_IDX_W-1:0];
        REG_PATH_FIRST:      wcfg.path_first  <= wr_data[CFG_IDX_W-1:0];
        REG_PATH_SPLIT:      wcfg.path_split  <= wr_data[CFG_IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lws_front #(
    .AHEAD_LEN  (AHEAD_LEN),
    .SIDE_LEN   (SIDE_LEN),
    .PATH_LEN   (PATH_LEN),
    .INDEX_BITS (INDEX_BITS),
    .RANGE_BITS (RANGE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .wcfg        (wcfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .range_mm    (range_mm),
    .last_sample (last_sample),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  lws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  lws_back #(
    .AHEAD_LEN (AHEAD_LEN),
    .SIDE_LEN  (SIDE_LEN)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .scfg           (scfg),
    .empty          (q_empty),
    .q_data         (pop_data),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .steering_mrad  (steering_mrad),
    .obstacle_ahead (obstacle_ahead)
  );

endmodule

// ----- hdl/lws_front.sv -----
// Front end: takes range samples, accumulates the three windows and the path maximum.
// Uses lws_pkg; pushes one scan_t per finished scan into the scan queue.
module lws_front import lws_pkg::*; #(
  parameter int AHEAD_LEN  = AHEAD_LEN_DEF,
  parameter int SIDE_LEN   = SIDE_LEN_DEF,
  parameter int PATH_LEN   = PATH_LEN_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int RANGE_BITS = RANGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  window_cfg_t        wcfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RANGE_W-1:0] range_mm,
  input  logic               last_sample,
  input  logic               q_full,
  output logic               q_push,
  output scan_t              q_data
);

  localparam int CW = ((INDEX_BITS > CFG_IDX_W) ? INDEX_BITS : CFG_IDX_W) + 1;
  localparam int AW = AHEAD_SUM_W + 1;
  localparam int SW = SIDE_SUM_W + 1;

  logic [INDEX_BITS-1:0]  sample_index;
  logic [AHEAD_SUM_W-1:0] ahead_sum, ahead_sum_next;
  logic [SIDE_SUM_W-1:0]  right_sum, right_sum_next;
  logic [SIDE_SUM_W-1:0]  left_sum, left_sum_next;
  logic [RANGE_BITS-1:0]  best_range, best_range_next;
  logic [INDEX_BITS-1:0]  best_index, best_index_next;

  logic                   accept;
  logic [RANGE_BITS-1:0]  r;
  logic [CW-1:0]          idx_w;
  logic                   in_ahead, in_right, in_left, in_path, take;
  logic [AW-1:0]          ahead_add;
  logic [SW-1:0]          right_add, left_add;

  function automatic logic in_win(input logic [CW-1:0] idx, input logic [CW-1:0] first,
                                  input logic [CW-1:0] len);
    logic [CW-1:0] diff;
    diff = idx - first;
    return (idx >= first) && (diff < len);
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && last_sample;

  always_comb begin
    r     = RANGE_BITS'(range_mm);
    idx_w = CW'(sample_index);

    in_ahead = in_win(idx_w, CW'(wcfg.ahead_first), CW'(AHEAD_LEN));
    in_right = in_win(idx_w, CW'(wcfg.right_first), CW'(SIDE_LEN));
    in_left  = in_win(idx_w, CW'(wcfg.left_first), CW'(SIDE_LEN));
    in_path  = in_win(idx_w, CW'(wcfg.path_first), CW'(PATH_LEN));

    ahead_add = {1'b0, ahead_sum} + AW'(r);
    right_add = {1'b0, right_sum} + SW'(r);
    left_add  = {1'b0, left_sum} + SW'(r);

    // clamp each sum at full scale
    ahead_sum_next = ahead_sum;
    if (in_ahead) begin
      ahead_sum_next = ahead_add[AHEAD_SUM_W] ? '1 : ahead_add[AHEAD_SUM_W-1:0];
    end
    right_sum_next = right_sum;
    if (in_right) begin
      right_sum_next = right_add[SIDE_SUM_W] ? '1 : right_add[SIDE_SUM_W-1:0];
    end
    left_sum_next = left_sum;
    if (in_left) begin
      left_sum_next = left_add[SIDE_SUM_W] ? '1 : left_add[SIDE_SUM_W-1:0];
    end

    // ties replace, so the last maximum wins
    take            = in_path && (r >= best_range);
    best_range_next = take ? r : best_range;
    best_index_next = take ? sample_index : best_index;

    q_data.ahead_sum = ahead_sum_next;
    q_data.right_sum = right_sum_next;
    q_data.left_sum  = left_sum_next;
    q_data.path_low  = CW'(best_index_next) < CW'(wcfg.path_split);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_sample)) begin
      sample_index <= '0;
      ahead_sum    <= '0;
      right_sum    <= '0;
      left_sum     <= '0;
      best_range   <= '0;
      best_index   <= '0;
    end else if (accept) begin
      sample_index <= sample_index + 1'b1;
      ahead_sum    <= ahead_sum_next;
      right_sum    <= right_sum_next;
      left_sum     <= left_sum_next;
      best_range   <= best_range_next;
      best_index   <= best_index_next;
    end
  end

endmodule

// ----- hdl/lws_queue.sv -----
// Short FIFO of finished scans between front and back end.
// Uses lws_pkg for the scan_t word; storage is in flip-flops.
module lws_queue import lws_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  scan_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output scan_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  scan_t          entries [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [NW-1:0]  count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == NW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

endmodule

// ----- hdl/lws_back.sv -----
// Back end: turns one finished scan into a steering word over a short pipeline.
// Uses lws_pkg; pops scans from lws_queue and holds the result in an output register.
module lws_back import lws_pkg::*; #(
  parameter int AHEAD_LEN = AHEAD_LEN_DEF,
  parameter int SIDE_LEN  = SIDE_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  steer_cfg_t                scfg,
  input  logic                      empty,
  input  scan_t                     q_data,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [STEER_W-1:0] steering_mrad,
  output logic                      obstacle_ahead
);

  localparam int OW0    = THR_W + $clog2(AHEAD_LEN + 1);
  localparam int OW     = (OW0 > AHEAD_SUM_W) ? OW0 : AHEAD_SUM_W;
  localparam int PROD_W = SIDE_SUM_W + GAIN_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int T_W    = SUM_W - GAIN_W;
  localparam longint unsigned Q_LIMIT = (64'd1 << (STEER_W - 1)) + 64'd1;
  localparam longint unsigned SAT_T   = Q_LIMIT * SIDE_LEN;
  localparam int TB     = $clog2(SAT_T + 1);
  localparam int RW     = TB + 1;
  localparam int MW     = TB + RW;
  localparam logic [RW-1:0]      RECIP    = RW'((64'd1 << TB) / SIDE_LEN);
  localparam logic [SUM_W-1:0]   HALF_DEN = SUM_W'(SIDE_LEN * (1 << (GAIN_W - 1)));
  localparam logic [STEER_W-1:0] NEG_CAP  = STEER_W'(1 << (STEER_W - 1));
  localparam logic [STEER_W-1:0] POS_CAP  = STEER_W'((1 << (STEER_W - 1)) - 1);

  logic adv;

  // stage valids
  logic a_valid, b_valid, c_valid, d_valid, e_valid;

  steer_flags_t a_flags, b_flags, c_flags, d_flags, e_flags, a_flags_next;
  logic [SIDE_SUM_W-1:0] a_mag, a_mag_next;
  logic [PROD_W-1:0]     b_prod;
  logic [TB-1:0]         c_t, d_t, e_t, c_t_next;
  logic [STEER_W-1:0]    d_q0, e_q0, d_q0_next;
  logic [TB-1:0]         e_qd;

  logic [SUM_W-1:0]      t_sum;
  logic [T_W-1:0]        t_full;
  logic [MW-1:0]         recip_prod;
  logic                  q_bump;
  logic [STEER_W-1:0]    q_fix, q_cap, turn_mag, steer_next;

  // the pipeline moves as a whole whenever the output register can take a word
  assign adv = !out_valid || out_ready;
  assign pop = adv && !empty;

  always_comb begin
    a_flags_next.obstacle = OW'(q_data.ahead_sum) <= OW'(scfg.threshold) * OW'(AHEAD_LEN);
    a_flags_next.neg      = q_data.right_sum > q_data.left_sum;
    a_flags_next.path_low = q_data.path_low;
    a_mag_next = a_flags_next.neg ? q_data.right_sum - q_data.left_sum
                                  : q_data.left_sum - q_data.right_sum;

    // round to nearest, then clip just above the largest magnitude
    t_sum    = {1'b0, b_prod} + HALF_DEN;
    t_full   = t_sum[SUM_W-1:GAIN_W];
    c_t_next = (t_full >= T_W'(SAT_T)) ? TB'(SAT_T) : t_full[TB-1:0];

    // reciprocal estimate is low by at most one
    recip_prod = MW'(c_t) * MW'(RECIP);
    d_q0_next  = recip_prod[TB +: STEER_W];

    q_bump = (e_t - e_qd) >= TB'(SIDE_LEN);
    q_fix  = e_q0 + STEER_W'(q_bump);

    turn_mag = STEER_W'(scfg.turn);
    q_cap    = q_fix;
    if (e_flags.obstacle) begin
      steer_next = e_flags.path_low ? -turn_mag : turn_mag;
    end else if (e_flags.neg) begin
      q_cap      = (q_fix > NEG_CAP) ? NEG_CAP : q_fix;
      steer_next = -q_cap;
    end else begin
      q_cap      = (q_fix > POS_CAP) ? POS_CAP : q_fix;
      steer_next = q_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= !empty;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_flags        <= a_flags_next;
      a_mag          <= a_mag_next;
      b_flags        <= a_flags;
      b_prod         <= PROD_W'(a_mag) * PROD_W'(scfg.gain);
      c_flags        <= b_flags;
      c_t            <= c_t_next;
      d_flags        <= c_flags;
      d_t            <= c_t;
      d_q0           <= d_q0_next;
      e_flags        <= d_flags;
      e_t            <= d_t;
      e_q0           <= d_q0;
      e_qd           <= TB'(d_q0) * TB'(SIDE_LEN);
      steering_mrad  <= steer_next;
      obstacle_ahead <= e_flags.obstacle;
    end
  end

endmodule

// ----- hdl/lws_checker.sv -----
// Port-level checks for lidar_window_steering_core, attached by bind.
// Uses lws_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module lws_checker import lws_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      last_sample,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [STEER_W-1:0] steering_mrad,
  input logic                      obstacle_ahead
);

  // scans closed at the input and not yet delivered
  logic [4:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 5'(in_valid && in_ready && last_sample)
                 - 5'(out_valid && out_ready);
    end
  end

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(steering_mrad) && $stable(obstacle_ahead), "result changed while stalled")
  `ASSERT_IMPLY(a_no_orphan, out_valid, pending != 5'd0, "result without a closed scan")
  `ASSERT_IMPLY(a_reset_idle, $past(rst), !out_valid, "result shown right after reset")
  `ASSERT_IMPLY(a_turn_range, out_valid && obstacle_ahead, steering_mrad != 13'h1000, "evasive turn out of range")

endmodule

bind lidar_window_steering_core lws_checker u_lws_checker (.*);

// ----- tb/lws_steer_checker.sv -----
// Scoreboard for the lidar window steering core. It follows the sample, register and
// steering channels, predicts each steering word and compares it field by field.
// Depends on lws_pkg only.
module lws_steer_checker import lws_pkg::*; #(
  parameter int AHEAD_LEN  = AHEAD_LEN_DEF,
  parameter int SIDE_LEN   = SIDE_LEN_DEF,
  parameter int PATH_LEN   = PATH_LEN_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [RANGE_W-1:0]        range_mm,
  input  logic                      last_sample,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [STEER_W-1:0] steering_mrad,
  input  logic                      obstacle_ahead,
  input  logic                      wr_en,
  input  logic [REG_ADDR_W-1:0]     wr_index,
  input  logic [REG_DATA_W-1:0]     wr_data,
  output int                        words_due,
  output int                        words_checked,
  output int                        mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned AHEAD_CAP = (64'd1 << AHEAD_SUM_W) - 1;
  localparam longint unsigned SIDE_CAP  = (64'd1 << SIDE_SUM_W) - 1;
  localparam longint unsigned STEER_POS_MAX = (64'd1 << (STEER_W - 1)) - 1;

  typedef struct {
    logic signed [STEER_W-1:0] steer;
    logic                      obstacle;
  } steer_word_t;

  logic [THR_W-1:0]       thr_cfg;
  logic [TURN_W-1:0]      turn_cfg;
  logic [GAIN_W-1:0]      gain_cfg;
  logic [CFG_IDX_W-1:0]   ahead_at, right_at, left_at, path_at, split_at;

  logic [INDEX_BITS-1:0]  scan_pos;
  logic [AHEAD_SUM_W-1:0] ahead_acc;
  logic [SIDE_SUM_W-1:0]  right_acc, left_acc;
  logic [RANGE_W-1:0]     peak_range;
  logic [INDEX_BITS-1:0]  peak_pos;

  steer_word_t steer_due_q[$];
  int          checked_cnt;
  int          mismatch_cnt;

  assign words_checked = checked_cnt;
  assign mismatches    = mismatch_cnt;

  task automatic flag_mismatch(input string what);
    $display("%t steer check: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  function automatic bit covers(input longint unsigned pos, input longint unsigned first,
                                input longint unsigned len);
    return pos >= first && pos - first < len;
  endfunction

  function automatic longint unsigned clip_add(input longint unsigned acc,
                                               input longint unsigned val,
                                               input longint unsigned cap);
    longint unsigned s;
    s = acc + val;
    return (s > cap) ? cap : s;
  endfunction

  function automatic void clear_scan();
    scan_pos   = '0;
    ahead_acc  = '0;
    right_acc  = '0;
    left_acc   = '0;
    peak_range = '0;
    peak_pos   = '0;
  endfunction

  // Steering word for the scan held in the accumulators right now.
  function automatic steer_word_t steer_for_scan();
    steer_word_t     w;
    longint unsigned a_sum, rs, ls, mag, q, den, thr_l;
    longint          s;
    bit              neg;
    a_sum = ahead_acc;
    rs    = right_acc;
    ls    = left_acc;
    thr_l = thr_cfg;
    den   = SIDE_LEN * 65536;
    w.obstacle = (a_sum <= thr_l * AHEAD_LEN);
    if (w.obstacle) begin
      s = (peak_pos < split_at) ? -longint'(turn_cfg) : longint'(turn_cfg);
    end else begin
      neg = rs > ls;
      mag = neg ? rs - ls : ls - rs;
      // round the magnitude half away from zero, sign goes on afterwards
      q = (mag * gain_cfg + den / 2) / den;
      if (neg) begin
        if (q > STEER_POS_MAX + 1) q = STEER_POS_MAX + 1;
        s = -longint'(q);
      end else begin
        if (q > STEER_POS_MAX) q = STEER_POS_MAX;
        s = longint'(q);
      end
    end
    w.steer = s[STEER_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    steer_word_t        want;
    logic [RANGE_W-1:0] r;
    if (rst) begin
      thr_cfg  = THRESHOLD_RST;
      turn_cfg = TURN_RST;
      gain_cfg = GAIN_RST;
      ahead_at = AHEAD_FIRST_RST;
      right_at = RIGHT_FIRST_RST;
      left_at  = LEFT_FIRST_RST;
      path_at  = PATH_FIRST_RST;
      split_at = PATH_SPLIT_RST;
      clear_scan();
      steer_due_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_AHEAD_THRESHOLD: thr_cfg  = wr_data[THR_W-1:0];
          REG_TURN:            turn_cfg = wr_data[TURN_W-1:0];
          REG_GAIN:            gain_cfg = wr_data[GAIN_W-1:0];
          REG_AHEAD_FIRST:     ahead_at = wr_data[CFG_IDX_W-1:0];
          REG_RIGHT_FIRST:     right_at = wr_data[CFG_IDX_W-1:0];
          REG_LEFT_FIRST:      left_at  = wr_data[CFG_IDX_W-1:0];
          REG_PATH_FIRST:      path_at  = wr_data[CFG_IDX_W-1:0];
          REG_PATH_SPLIT:      split_at = wr_data[CFG_IDX_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (steer_due_q.size() == 0) begin
          flag_mismatch($sformatf("steering word %0d obstacle %0b with none due",
                                  steering_mrad, obstacle_ahead));
        end else begin
          want = steer_due_q.pop_front();
          if (steering_mrad !== want.steer)
            flag_mismatch($sformatf("word %0d: steering %0d, want %0d",
                                    checked_cnt, steering_mrad, want.steer));
          if (obstacle_ahead !== want.obstacle)
            flag_mismatch($sformatf("word %0d: obstacle %0b, want %0b",
                                    checked_cnt, obstacle_ahead, want.obstacle));
          checked_cnt++;
        end
      end

      if (in_valid && in_ready) begin
        r = range_mm;
        if (covers(scan_pos, ahead_at, AHEAD_LEN))
          ahead_acc = AHEAD_SUM_W'(clip_add(ahead_acc, r, AHEAD_CAP));
        if (covers(scan_pos, right_at, SIDE_LEN))
          right_acc = SIDE_SUM_W'(clip_add(right_acc, r, SIDE_CAP));
        if (covers(scan_pos, left_at, SIDE_LEN))
          left_acc = SIDE_SUM_W'(clip_add(left_acc, r, SIDE_CAP));
        // ties move the peak forward
        if (covers(scan_pos, path_at, PATH_LEN) && r >= peak_range) begin
          peak_range = r;
          peak_pos   = scan_pos;
        end
        if (last_sample) begin
          steer_due_q.push_back(steer_for_scan());
          clear_scan();
        end else begin
          scan_pos = scan_pos + 1'b1;
        end
      end
    end
    words_due <= steer_due_q.size();
  end

endmodule

// ----- tb/tb_lidar_window_steering_core.sv -----
// Top of the lidar window steering testbench: clock, reset, sample and register stimulus,
// output back-pressure and the verdict. Depends on lws_pkg, lws_steer_checker and the
// lidar_window_steering_core RTL.
module tb_lidar_window_steering_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lws_pkg::*;

  localparam int RANDOM_SAMPLES = 580;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 400;
  localparam int FLOOD_SCANS    = 40;

  typedef enum int {FILL_RANDOM, FILL_LOW, FILL_FLAT, FILL_NEAR, FILL_EDGE} fill_e;
  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_BEAT} stall_e;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [RANGE_W-1:0]        range_mm;
  logic                      last_sample;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [STEER_W-1:0] steering_mrad;
  logic                      obstacle_ahead;
  logic                      wr_en;
  logic [REG_ADDR_W-1:0]     wr_index;
  logic [REG_DATA_W-1:0]     wr_data;
  logic                      flood_on;

  int words_due, words_checked, mismatches;
  int samples_sent, scans_sent, reg_writes;
  int burst_left;

  lidar_window_steering_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .range_mm       (range_mm),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .steering_mrad  (steering_mrad),
    .obstacle_ahead (obstacle_ahead),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data)
  );

  lws_steer_checker steer_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .range_mm       (range_mm),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .steering_mrad  (steering_mrad),
    .obstacle_ahead (obstacle_ahead),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .words_due      (words_due),
    .words_checked  (words_checked),
    .mismatches     (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_lidar_window_steering_core: done, errors");
    $finish;
  end

  // Offer one sample word and hold it until the core takes it.
  task automatic push_sample(input logic [RANGE_W-1:0] r, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    range_mm    <= r;
    last_sample <= lst;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    if (lst) scans_sent++;
  endtask

  // Drop valid and wait until every steering word due has come back.
  task automatic drain_block();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_ADDR_W-1:0] idx, input logic [REG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic load_settings(input logic [REG_DATA_W-1:0] thr, turn, gain,
                               ahead_first, right_first, left_first,
                               path_first, path_split);
    write_reg(REG_AHEAD_THRESHOLD, thr);
    write_reg(REG_TURN, turn);
    write_reg(REG_GAIN, gain);
    write_reg(REG_AHEAD_FIRST, ahead_first);
    write_reg(REG_RIGHT_FIRST, right_first);
    write_reg(REG_LEFT_FIRST, left_first);
    write_reg(REG_PATH_FIRST, path_first);
    write_reg(REG_PATH_SPLIT, path_split);
    wr_en <= 1'b0;
  endtask

  function automatic logic [REG_DATA_W-1:0] pick_first();
    logic [REG_DATA_W-1:0] v;
    // mostly near the scan start so short scans reach the windows
    if ($urandom_range(0, 9) < 7) v = REG_DATA_W'($urandom_range(0, 40));
    else v = REG_DATA_W'($urandom());
    return v;
  endfunction

  task automatic load_random_settings(output logic [REG_DATA_W-1:0] thr);
    logic [REG_DATA_W-1:0] gain, split;
    case ($urandom_range(0, 3))
      0:       thr = '0;
      1:       thr = '1;
      2:       thr = REG_DATA_W'($urandom_range(0, 4000));
      default: thr = REG_DATA_W'($urandom());
    endcase
    case ($urandom_range(0, 3))
      0:       gain = REG_DATA_W'($urandom_range(0, 2000));
      1:       gain = $urandom_range(0, 1) ? '1 : '0;
      default: gain = REG_DATA_W'($urandom());
    endcase
    if ($urandom_range(0, 4) != 0) split = REG_DATA_W'($urandom_range(0, 60));
    else split = REG_DATA_W'($urandom());
    load_settings(thr, REG_DATA_W'($urandom()), gain, pick_first(), pick_first(),
                  pick_first(), pick_first(), split);
  endtask

  function automatic logic [RANGE_W-1:0] pick_range(input fill_e fill,
                                                    input logic [RANGE_W-1:0] base);
    logic [RANGE_W-1:0] v;
    case (fill)
      FILL_LOW:  v = RANGE_W'($urandom_range(0, 255));
      FILL_FLAT: v = base;
      FILL_NEAR: v = base + RANGE_W'($urandom_range(0, 6)) - RANGE_W'(3);
      FILL_EDGE: v = $urandom_range(0, 1) ? {RANGE_W{1'b1}} : '0;
      default:   v = RANGE_W'($urandom());
    endcase
    return v;
  endfunction

  task automatic send_scan(input int len, input fill_e fill, input logic [RANGE_W-1:0] base);
    int k;
    for (k = 0; k < len; k++) push_sample(pick_range(fill, base), k == len - 1);
  endtask

  // Output side: changing stall patterns, plus one long hold-off during the flood phase.
  initial begin : result_sink
    stall_e mode;
    int     span, k;
    bit     held;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      if (flood_on && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = stall_e'($urandom_range(0, 3));
        span = $urandom_range(8, 80);
        for (k = 0; k < span; k++) begin
          case (mode)
            STALL_NONE:  out_ready <= 1'b1;
            STALL_HALF:  out_ready <= 1'($urandom_range(0, 1));
            STALL_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
            default:     out_ready <= (k % 5 != 4);
          endcase
          @(posedge clk);
          if (flood_on && !held) break;
        end
      end
    end
  end

  initial begin : stimulus
    int                    nscans, len, roll, rand_start;
    fill_e                 fill;
    logic [REG_DATA_W-1:0] thr;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    range_mm    <= '0;
    last_sample <= 1'b0;
    wr_en       <= 1'b0;
    wr_index    <= '0;
    wr_data     <= '0;
    flood_on    <= 1'b0;
    burst_left  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one scan under the reset settings, long enough to cover every default window
    send_scan(880, FILL_RANDOM, '0);
    drain_block();

    // rounding tie: half a milliradian goes away from zero, both signs
    load_settings(16'd0, 16'd4095, 16'd32768, 16'd0, 16'd4095, 16'd0, 16'd0, 16'd0);
    send_scan(1, FILL_FLAT, 16'd136);
    drain_block();
    load_settings(16'd0, 16'd4095, 16'd32768, 16'd0, 16'd0, 16'd4095, 16'd0, 16'd0);
    send_scan(1, FILL_FLAT, 16'd136);
    drain_block();
    // equal sides steer straight
    load_settings(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_scan(1, FILL_FLAT, 16'hFFFF);
    drain_block();
    // clip the balance term at both ends
    load_settings(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd4095, 16'd0, 16'd0, 16'd0);
    send_scan(9, FILL_FLAT, 16'hFFFF);
    drain_block();
    load_settings(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd4095, 16'd0, 16'd0);
    send_scan(9, FILL_FLAT, 16'hFFFF);
    drain_block();
    // ahead sum exactly at the limit, then one above it
    load_settings(16'd1000, 16'd2047, 16'd0, 16'd0, 16'd4095, 16'd4095, 16'd0, 16'd1);
    send_scan(1, FILL_FLAT, 16'd23000);
    send_scan(1, FILL_FLAT, 16'd23001);
    drain_block();
    // equal path peaks: the later one wins
    load_settings(16'hFFFF, 16'd1234, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    send_scan(2, FILL_FLAT, 16'd5);
    drain_block();
    // no path sample at all leaves the peak index at zero
    load_settings(16'hFFFF, 16'd1234, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4095, 16'd1);
    send_scan(1, FILL_FLAT, 16'hFFFF);
    drain_block();

    rand_start = samples_sent;
    while (samples_sent - rand_start < RANDOM_SAMPLES) begin
      load_random_settings(thr);
      nscans = $urandom_range(1, 8);
      repeat (nscans) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) len = $urandom_range(1, 30);
        else if (roll < 97) len = $urandom_range(31, 160);
        else len = $urandom_range(161, 500);
        fill = fill_e'($urandom_range(0, 4));
        send_scan(len, fill, (fill == FILL_NEAR) ? thr : RANGE_W'($urandom()));
      end
      drain_block();
    end

    // short scans against a held output: fill the result queue and back up the input
    load_random_settings(thr);
    flood_on <= 1'b1;
    repeat (FLOOD_SCANS) send_scan($urandom_range(1, 2), FILL_RANDOM, '0);
    flood_on <= 1'b0;
    drain_block();

    $display("summary: %0d samples in %0d scans, %0d steering words checked, %0d reg writes",
             samples_sent, scans_sent, words_checked, reg_writes);
    $display("summary: rounding ties, balance clipping, ahead limit, path ties, %0d-cycle hold",
             LONG_HOLD);
    if (mismatches == 0 && words_due == 0) begin
      $display("tb_lidar_window_steering_core: done, clean");
    end else begin
      $display("tb_lidar_window_steering_core: done, errors");
    end
    $finish;
  end

endmodule
